[rtl/pac_pkg.sv]
package pac_pkg;

  localparam int unsigned MaxVertices = 256;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned CntW        = 9;
  localparam int unsigned SumW        = 41;
  localparam int unsigned CrossW      = 33;
  localparam int unsigned PairW       = 17;
  localparam int unsigned MomTermW    = 50;
  localparam int unsigned MomW        = 58;
  localparam int unsigned AreaW       = 39;
  localparam int unsigned RefW        = 39;
  localparam int unsigned RatioW      = 32;
  localparam int unsigned NumW        = 58;
  localparam int unsigned DenW        = 43;
  localparam int unsigned DivCntW     = 6;
  localparam int unsigned RatioShift  = 15;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusZeroArea = 2'd1;
  localparam logic [1:0] StatusZeroRef  = 2'd2;
  localparam logic [1:0] StatusOverflow = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] e_px;
    logic signed [CoordW-1:0] e_py;
    logic signed [CoordW-1:0] e_qx;
    logic signed [CoordW-1:0] e_qy;
    logic signed [CoordW-1:0] c_px;
    logic signed [CoordW-1:0] c_py;
    logic signed [CoordW-1:0] f_x;
    logic signed [CoordW-1:0] f_y;
    logic                     add_edge;
    logic                     last;
    logic                     ovf;
  } pac_item_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } pac_div_req_t;

  function automatic logic signed [CoordW-1:0] sat_cent(logic [NumW-1:0] mag, logic neg);
    logic signed [CoordW-1:0] r;
    if (!neg) begin
      if (mag > NumW'(32767)) r = 16'sh7fff;
      else r = mag[CoordW-1:0];
    end else begin
      if (mag > NumW'(32768)) r = 16'sh8000;
      else r = -mag[CoordW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [RatioW-1:0] sat_ratio(logic [NumW-1:0] mag, logic neg);
    logic signed [RatioW-1:0] r;
    if (!neg) begin
      if (mag > NumW'(32'h7fff_ffff)) r = 32'sh7fff_ffff;
      else r = mag[RatioW-1:0];
    end else begin
      if (mag > NumW'(33'h0_8000_0000)) r = 32'sh8000_0000;
      else r = -mag[RatioW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [AreaW-1:0] sat_area(logic signed [SumW-1:0] s);
    logic signed [SumW-1:0]  h;
    logic signed [AreaW-1:0] r;
    h = $signed(s + SumW'(s[SumW-1])) >>> 1;
    if (h[SumW-1:AreaW-1] == '0 || h[SumW-1:AreaW-1] == '1) r = h[AreaW-1:0];
    else if (h[SumW-1]) r = {1'b1, {(AreaW-1){1'b0}}};
    else r = {1'b0, {(AreaW-1){1'b1}}};
    return r;
  endfunction

endpackage

[rtl/pac_front.sv]
module pac_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic signed [15:0]  vertex_x_i,
  input  logic signed [15:0]  vertex_y_i,
  input  logic                last_i,
  input  logic                q_full_i,
  output logic                push_o,
  output pac_pkg::pac_item_t  item_o
);
  import pac_pkg::*;

  logic signed [CoordW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [CoordW-1:0] first_x_d, first_y_d, prev_x_d, prev_y_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     drop;

  assign push_o = in_valid_i && !q_full_i;
  assign drop   = cnt_q >= CntW'(MaxVertices);

  always_comb begin
    prev_x_d  = drop ? prev_x_q : vertex_x_i;
    prev_y_d  = drop ? prev_y_q : vertex_y_i;
    first_x_d = (!drop && cnt_q == '0) ? vertex_x_i : first_x_q;
    first_y_d = (!drop && cnt_q == '0) ? vertex_y_i : first_y_q;
    cnt_d     = drop ? CntW'(MaxVertices + 1) : cnt_q + 1'b1;

    item_o.e_px     = prev_x_q;
    item_o.e_py     = prev_y_q;
    item_o.e_qx     = vertex_x_i;
    item_o.e_qy     = vertex_y_i;
    item_o.c_px     = prev_x_d;
    item_o.c_py     = prev_y_d;
    item_o.f_x      = first_x_d;
    item_o.f_y      = first_y_d;
    item_o.add_edge = !drop && cnt_q != '0;
    item_o.last     = last_i;
    item_o.ovf      = cnt_d > CntW'(MaxVertices);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      cnt_q     <= '0;
    end else if (push_o) begin
      if (last_i) begin
        first_x_q <= '0;
        first_y_q <= '0;
        prev_x_q  <= '0;
        prev_y_q  <= '0;
        cnt_q     <= '0;
      end else begin
        first_x_q <= first_x_d;
        first_y_q <= first_y_d;
        prev_x_q  <= prev_x_d;
        prev_y_q  <= prev_y_d;
        cnt_q     <= cnt_d;
      end
    end
  end

endmodule

[rtl/pac_queue.sv]
module pac_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pac_pkg::pac_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output pac_pkg::pac_item_t item_o
);
  import pac_pkg::*;

  pac_item_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign item_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

[rtl/pac_div.sv]
module pac_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pac_pkg::pac_div_req_t       req_i,
  output logic                        done_o,
  output logic [pac_pkg::NumW-1:0]    quo_o
);
  import pac_pkg::*;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DenW-1:0]    rem_q, den_q;
  logic [NumW-1:0]    num_q, quo_q;
  logic [DenW:0]      trial, diff;
  logic               fits;

  assign trial  = {rem_q, num_q[NumW-1]};
  assign diff   = trial - {1'b0, den_q};
  assign fits   = !diff[DenW];
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      den_q <= req_i.den;
      num_q <= req_i.num;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DenW-1:0] : trial[DenW-1:0];
      num_q <= {num_q[NumW-2:0], 1'b0};
      quo_q <= {quo_q[NumW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/pac_back.sv]
module pac_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_empty_i,
  input  pac_pkg::pac_item_t               item_i,
  output logic                             pop_o,
  input  logic signed [pac_pkg::RefW-1:0]  ref_area_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [38:0]               area_o,
  output logic signed [15:0]               centroid_x_o,
  output logic signed [15:0]               centroid_y_o,
  output logic signed [31:0]               rel_area_o,
  output logic [1:0]                       status_o
);
  import pac_pkg::*;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMul1 = 4'd1;
  localparam logic [3:0] StMul2 = 4'd2;
  localparam logic [3:0] StMul3 = 4'd3;
  localparam logic [3:0] StAcc  = 4'd4;
  localparam logic [3:0] StFin  = 4'd5;
  localparam logic [3:0] StDivX = 4'd6;
  localparam logic [3:0] StDivY = 4'd7;
  localparam logic [3:0] StDivR = 4'd8;
  localparam logic [3:0] StOut  = 4'd9;

  logic [3:0] state_q;

  logic signed [CoordW-1:0]   op_px_q, op_py_q, op_qx_q, op_qy_q;
  logic signed [CoordW-1:0]   cl_px_q, cl_py_q, cl_fx_q, cl_fy_q;
  logic                       close_q, last_q, ovf_q;
  logic signed [2*CoordW-1:0] p1_q, p2_q;
  logic signed [PairW-1:0]    sx_q, sy_q;
  logic signed [CrossW-1:0]   c_q;
  logic signed [MomTermW-1:0] mx_q, my_q;
  logic signed [SumW-1:0]     s_sum_q;
  logic signed [MomW-1:0]     mx_sum_q, my_sum_q;

  logic signed [AreaW-1:0]    res_area_q;
  logic signed [CoordW-1:0]   res_cx_q, res_cy_q;
  logic signed [RatioW-1:0]   res_ratio_q;
  logic [1:0]                 res_status_q;

  logic                       out_free;
  logic signed [SumW+1:0]     s3;
  logic [DenW-1:0]            abs_s3, abs_ref;
  logic [NumW-1:0]            abs_mx, abs_my, ratio_num;
  logic [SumW-1:0]            abs_s;
  pac_div_req_t               div_req;
  logic                       div_done;
  logic [NumW-1:0]            div_quo;

  assign pop_o    = state_q == StIdle && !q_empty_i;
  assign out_free = !out_valid_o || !out_stall_i;

  assign s3        = (SumW+2)'(s_sum_q) + ((SumW+2)'(s_sum_q) <<< 1);
  assign abs_s3    = s3[SumW+1] ? DenW'(-s3) : DenW'(s3);
  assign abs_s     = s_sum_q[SumW-1] ? SumW'(-s_sum_q) : SumW'(s_sum_q);
  assign abs_mx    = mx_sum_q[MomW-1] ? NumW'(-mx_sum_q) : NumW'(mx_sum_q);
  assign abs_my    = my_sum_q[MomW-1] ? NumW'(-my_sum_q) : NumW'(my_sum_q);
  assign ratio_num = NumW'(abs_s) << RatioShift;
  assign abs_ref   = ref_area_i[RefW-1] ? DenW'(-(DenW'(ref_area_i)))
                                        : DenW'(ref_area_i);

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = abs_mx;
    div_req.den   = abs_s3;
    unique case (state_q)
      StFin: div_req.start = !ovf_q && s_sum_q != '0;
      StDivX: begin
        div_req.start = div_done;
        div_req.num   = abs_my;
      end
      StDivY: begin
        div_req.start = div_done && ref_area_i != '0;
        div_req.num   = ratio_num;
        div_req.den   = abs_ref;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  pac_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (pop_o) begin
          cl_px_q <= item_i.c_px;
          cl_py_q <= item_i.c_py;
          cl_fx_q <= item_i.f_x;
          cl_fy_q <= item_i.f_y;
          last_q  <= item_i.last;
          ovf_q   <= item_i.ovf;
          close_q <= !item_i.add_edge;
          if (item_i.add_edge) begin
            op_px_q <= item_i.e_px;
            op_py_q <= item_i.e_py;
            op_qx_q <= item_i.e_qx;
            op_qy_q <= item_i.e_qy;
          end else begin
            op_px_q <= item_i.c_px;
            op_py_q <= item_i.c_py;
            op_qx_q <= item_i.f_x;
            op_qy_q <= item_i.f_y;
          end
        end
      end
      StMul1: begin
        p1_q <= op_px_q * op_qy_q;
        p2_q <= op_qx_q * op_py_q;
        sx_q <= PairW'(op_px_q) + PairW'(op_qx_q);
        sy_q <= PairW'(op_py_q) + PairW'(op_qy_q);
      end
      StMul2: c_q <= CrossW'(p1_q) - CrossW'(p2_q);
      StMul3: begin
        mx_q <= sx_q * c_q;
        my_q <= sy_q * c_q;
      end
      StAcc: begin
        if (!close_q && last_q && !ovf_q) begin
          close_q <= 1'b1;
          op_px_q <= cl_px_q;
          op_py_q <= cl_py_q;
          op_qx_q <= cl_fx_q;
          op_qy_q <= cl_fy_q;
        end
      end
      StFin: begin
        res_cx_q    <= '0;
        res_cy_q    <= '0;
        res_ratio_q <= '0;
        if (ovf_q) begin
          res_status_q <= StatusOverflow;
          res_area_q   <= '0;
        end else if (s_sum_q == '0) begin
          res_status_q <= StatusZeroArea;
          res_area_q   <= '0;
        end else begin
          res_status_q <= StatusOk;
          res_area_q   <= sat_area(s_sum_q);
        end
      end
      StDivX: begin
        if (div_done) begin
          res_cx_q <= sat_cent(div_quo, mx_sum_q[MomW-1] ^ s_sum_q[SumW-1]);
          if (ref_area_i == '0) res_status_q <= StatusZeroRef;
        end
      end
      StDivY: begin
        if (div_done) res_cy_q <= sat_cent(div_quo, my_sum_q[MomW-1] ^ s_sum_q[SumW-1]);
      end
      StDivR: begin
        if (div_done) begin
          res_ratio_q <= sat_ratio(div_quo, s_sum_q[SumW-1] ^ ref_area_i[RefW-1]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StOut && out_free) begin
      area_o       <= res_area_q;
      centroid_x_o <= res_cx_q;
      centroid_y_o <= res_cy_q;
      rel_area_o   <= res_ratio_q;
      status_o     <= res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_o <= 1'b0;
      s_sum_q     <= '0;
      mx_sum_q    <= '0;
      my_sum_q    <= '0;
    end else begin
      if (state_q == StOut && out_free) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (pop_o) begin
            if (item_i.add_edge || (item_i.last && !item_i.ovf)) state_q <= StMul1;
            else if (item_i.last) state_q <= StFin;
          end
        end
        StMul1: state_q <= StMul2;
        StMul2: state_q <= StMul3;
        StMul3: state_q <= StAcc;
        StAcc: begin
          s_sum_q  <= s_sum_q + SumW'(c_q);
          mx_sum_q <= mx_sum_q + MomW'(mx_q);
          my_sum_q <= my_sum_q + MomW'(my_q);
          if (!close_q && last_q && !ovf_q) state_q <= StMul1;
          else if (last_q) state_q <= StFin;
          else state_q <= StIdle;
        end
        StFin: begin
          if (ovf_q || s_sum_q == '0) state_q <= StOut;
          else state_q <= StDivX;
        end
        StDivX: if (div_done) state_q <= StDivY;
        StDivY: begin
          if (div_done) state_q <= (ref_area_i == '0) ? StOut : StDivR;
        end
        StDivR: if (div_done) state_q <= StOut;
        StOut: begin
          if (out_free) begin
            s_sum_q  <= '0;
            mx_sum_q <= '0;
            my_sum_q <= '0;
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

[rtl/polygon_area_centroid_unit.sv]
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    vertex_x_i, vertex_y_i, last_i
// out      output     out_valid_o / out_stall_i  area_o, centroid_x_o, centroid_y_o,
//                                                rel_area_o, status_o
// cfg      input      cfg_we_i                   cfg_wdata_i (reference area)
//
// In the back end a vertex leaves the queue and then passes two multiply
// stages, one subtract and one accumulate.
// The last vertex adds the closing edge unless the polygon has overflowed,
// and then up to three divisions run on one shared radix-2 divider.
// Reset clears the polygon state, the queue and the reference area.
// A two-entry queue lets the front take vertices while the back is busy or stalled.
module polygon_area_centroid_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  vertex_x_i,
  input  logic signed [15:0]  vertex_y_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [38:0]  area_o,
  output logic signed [15:0]  centroid_x_o,
  output logic signed [15:0]  centroid_y_o,
  output logic signed [31:0]  rel_area_o,
  output logic [1:0]          status_o,
  input  logic                cfg_we_i,
  input  logic signed [38:0]  cfg_wdata_i
);
  import pac_pkg::*;

  logic signed [RefW-1:0] ref_area_q;
  logic                   q_full, q_empty, push, pop;
  pac_item_t              item_in, item_out;

  assign in_stall_o = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_area_q <= '0;
    end else if (cfg_we_i) begin
      ref_area_q <= cfg_wdata_i;
    end
  end

  pac_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .vertex_x_i (vertex_x_i),
    .vertex_y_i (vertex_y_i),
    .last_i     (last_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (item_in)
  );

  pac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (item_out)
  );

  pac_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .item_i       (item_out),
    .pop_o        (pop),
    .ref_area_i   (ref_area_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .area_o       (area_o),
    .centroid_x_o (centroid_x_o),
    .centroid_y_o (centroid_y_o),
    .rel_area_o   (rel_area_o),
    .status_o     (status_o)
  );

  a_zero_area_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatusZeroArea |->
      area_o == '0 && centroid_x_o == '0 && centroid_y_o == '0 && rel_area_o == '0)
    else $error("zero-area result carries nonzero fields");

  a_overflow_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatusOverflow |-> area_o == '0 && rel_area_o == '0)
    else $error("overflow result carries nonzero fields");

  a_zero_ref_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatusZeroRef |-> rel_area_o == '0)
    else $error("zero-reference result carries a ratio");

endmodule

[dv/polygon_area_centroid_unit_tb.sv]
module polygon_area_centroid_unit_tb;
  import pac_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 250;
  localparam int unsigned RandomItems   = 300;

  typedef struct {
    logic signed [AreaW-1:0]  area;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [RatioW-1:0] ratio;
    logic [1:0]               status;
  } polygon_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] vertex_x_i;
  logic signed [15:0] vertex_y_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [38:0] area_o;
  logic signed [15:0] centroid_x_o;
  logic signed [15:0] centroid_y_o;
  logic signed [31:0] rel_area_o;
  logic [1:0]         status_o;
  logic               cfg_we_i;
  logic signed [38:0] cfg_wdata_i;

  polygon_result_t expected_results[$];
  int unsigned     error_count;
  int unsigned     vertices_sent;
  bit              no_gaps;
  bit              rx_no_stall;
  int unsigned     hold_request;
  int unsigned     hold_left;
  int unsigned     stall_left;
  int unsigned     quiet_cycles;

  longint      ref_area;
  longint      first_x, first_y, prev_x, prev_y;
  longint      twice_area, moment_x, moment_y;
  int unsigned vertex_count;

  polygon_area_centroid_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .vertex_x_i  (vertex_x_i),
    .vertex_y_i  (vertex_y_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .area_o      (area_o),
    .centroid_x_o(centroid_x_o),
    .centroid_y_o(centroid_y_o),
    .rel_area_o  (rel_area_o),
    .status_o    (status_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void accumulate_edge(longint px, longint py, longint qx, longint qy);
    longint c;
    c = px * qy - qx * py;
    twice_area += c;
    moment_x   += (px + qx) * c;
    moment_y   += (py + qy) * c;
  endfunction

  function automatic void clear_polygon();
    first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
    twice_area = 0; moment_x = 0; moment_y = 0;
    vertex_count = 0;
  endfunction

  function automatic void predict_vertex(longint x, longint y, bit is_last);
    polygon_result_t r;
    if (vertex_count >= MaxVertices) begin
      vertex_count = MaxVertices + 1;
    end else begin
      if (vertex_count == 0) begin
        first_x = x;
        first_y = y;
      end else begin
        accumulate_edge(prev_x, prev_y, x, y);
      end
      prev_x = x;
      prev_y = y;
      vertex_count++;
    end
    if (!is_last) return;
    r.area = '0; r.cx = '0; r.cy = '0; r.ratio = '0; r.status = StatusOk;
    if (vertex_count > MaxVertices) begin
      r.status = StatusOverflow;
    end else begin
      accumulate_edge(prev_x, prev_y, first_x, first_y);
      if (twice_area == 0) begin
        r.status = StatusZeroArea;
      end else begin
        r.area = AreaW'(clamp(twice_area / 2, AreaW));
        r.cx   = CoordW'(clamp(moment_x / (3 * twice_area), CoordW));
        r.cy   = CoordW'(clamp(moment_y / (3 * twice_area), CoordW));
        if (ref_area == 0) r.status = StatusZeroRef;
        else r.ratio = RatioW'(clamp((twice_area * 32768) / ref_area, RatioW));
      end
    end
    expected_results.insert(expected_results.size(), r);
    clear_polygon();
  endfunction

  // Leaves in_valid_i high after the transfer so that a back-to-back vertex
  // keeps in_valid_i high without a gap.
  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, bit is_last);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_x_i <= x;
    vertex_y_i <= y;
    last_i     <= is_last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_vertex(x, y, is_last);
    vertices_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reference(longint value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[38:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ref_area = longint'($signed(value[38:0]));
  endtask

  function automatic logic signed [15:0] random_coord(bit narrow);
    if (narrow) return $signed(16'($urandom_range(0, 255)) - 16'd128);
    return $signed(16'($urandom()));
  endfunction

  task automatic send_random_polygon(int unsigned n, bit narrow);
    for (int unsigned i = 0; i < n; i++) begin
      send_vertex(random_coord(narrow), random_coord(narrow), i == n - 1);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_result();
      stall_left = rx_no_stall ? 0 : $urandom_range(0, 11);
    end else if (stall_left == 0 && !rx_no_stall && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 11);
    end
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_result();
    polygon_result_t e;
    if (expected_results.size() == 0) begin
      $display("%0t: result transfer with nothing expected, area %0d status %0d",
               $time, area_o, status_o);
      error_count++;
      return;
    end
    e = expected_results.pop_front();
    if (area_o !== e.area) begin
      $display("%0t: area expected %0d actual %0d", $time, e.area, area_o);
      error_count++;
    end
    if (centroid_x_o !== e.cx) begin
      $display("%0t: centroid_x expected %0d actual %0d", $time, e.cx, centroid_x_o);
      error_count++;
    end
    if (centroid_y_o !== e.cy) begin
      $display("%0t: centroid_y expected %0d actual %0d", $time, e.cy, centroid_y_o);
      error_count++;
    end
    if (rel_area_o !== e.ratio) begin
      $display("%0t: rel_area expected %0d actual %0d", $time, e.ratio, rel_area_o);
      error_count++;
    end
    if (status_o !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // The reference area is still zero from reset here.
  task automatic test_zero_reference();
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd100, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd100, 1'b1);
    send_random_polygon(5, 1'b0);
  endtask

  task automatic test_directed_shapes();
    write_reference(longint'(1) <<< 8);
    send_vertex(-16'sd32768, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 1'b0);
    send_vertex(-16'sd32768, 16'sd32767, 1'b1);
    send_vertex(-16'sd32768, 16'sd32767, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 1'b0);
    send_vertex(16'sd32767, -16'sd32768, 1'b0);
    send_vertex(-16'sd32768, -16'sd32768, 1'b1);
    // A single vertex and a two-vertex polygon both have zero area.
    send_vertex(16'sd1234, -16'sd77, 1'b1);
    send_vertex(16'sd5, 16'sd5, 1'b0);
    send_vertex(-16'sd9, 16'sd3, 1'b1);
    // Unit triangles in both windings give an area that truncates to zero.
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd1, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd1, 1'b1);
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd1, 1'b0);
    send_vertex(16'sd1, 16'sd0, 1'b1);
    send_vertex(16'sd16, 16'sd16, 1'b0);
    send_vertex(16'sd32, 16'sd32, 1'b0);
    send_vertex(16'sd48, 16'sd48, 1'b1);
  endtask

  task automatic test_vertex_limit();
    send_random_polygon(MaxVertices, 1'b0);
    send_random_polygon(MaxVertices + 4, 1'b1);
  endtask

  task automatic test_reference_extremes();
    longint values[5];
    values[0] = 1;
    values[1] = -1;
    values[2] = (longint'(1) <<< 38) - 1;
    values[3] = -(longint'(1) <<< 38);
    values[4] = longint'($signed(39'({$urandom(), $urandom()})));
    foreach (values[i]) begin
      write_reference(values[i]);
      send_random_polygon(4, 1'b0);
      send_random_polygon(3, 1'b1);
    end
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    no_gaps      = 1'b1;
    hold_request = 400;
    for (int i = 0; i < 4; i++) send_random_polygon(6, 1'b1);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_polygons();
    int unsigned target;
    int unsigned kind;
    target = vertices_sent + RandomItems;
    while (vertices_sent < target) begin
      no_gaps     = ($urandom_range(0, 3) == 0);
      rx_no_stall = ($urandom_range(0, 4) == 0);
      kind        = $urandom_range(0, 19);
      if (kind == 0) begin
        write_reference(longint'($signed(39'({$urandom(), $urandom()}))));
      end else if (kind == 1) begin
        write_reference(longint'($urandom_range(1, 4096)) <<< 8);
      end else if (kind < 4) begin
        send_random_polygon($urandom_range(1, 2), $urandom_range(0, 1));
      end else if (kind < 11) begin
        send_random_polygon($urandom_range(3, 12), 1'b1);
      end else begin
        send_random_polygon($urandom_range(3, 12), 1'b0);
      end
    end
    no_gaps     = 1'b0;
    rx_no_stall = 1'b0;
  endtask

  initial begin
    clear_polygon();
    ref_area      = 0;
    error_count   = 0;
    vertices_sent = 0;
    no_gaps       = 1'b0;
    rx_no_stall   = 1'b0;
    hold_request  = 0;
    hold_left     = 0;
    stall_left    = 0;
    quiet_cycles  = 0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    vertex_x_i    <= '0;
    vertex_y_i    <= '0;
    last_i        <= 1'b0;
    out_stall_i   <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_reference();
    test_directed_shapes();
    test_vertex_limit();
    test_reference_extremes();
    test_output_backpressure();
    test_random_polygons();
    wait_idle();

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pac_pkg.sv
rtl/pac_front.sv
rtl/pac_queue.sv
rtl/pac_div.sv
rtl/pac_back.sv
rtl/polygon_area_centroid_unit.sv
dv/polygon_area_centroid_unit_tb.sv
